// ----- rtl/core/cwtc_pkg.sv -----
// Package: shared constants, types and helpers for the whitespace/tab compressor.
`default_nettype none
package cwtc_pkg;

    localparam int POS_BITS  = 8;                 // column counter width
    localparam int TAB_BITS  = 5;                 // tab width register / divisor width
    localparam int REM_BITS  = 4;                 // remainder of a divide by 1..16
    localparam int CNT_BITS  = $clog2(POS_BITS);  // divider step counter
    localparam int LINE_BITS = 8;
    localparam int CFG_BITS  = 2;

    localparam logic [POS_BITS-1:0]  POS_MAX        = '1;
    localparam logic [LINE_BITS-1:0] LINE_MAX       = '1;
    localparam logic [7:0]           MIN_WRAP_WIDTH = 8'd20;
    localparam logic [7:0]           MIN_PAGE_LINES = 8'd3;

    // reset values of the configuration registers
    localparam logic [TAB_BITS-1:0] RST_TAB_WIDTH  = 5'd8;
    localparam logic [7:0]          RST_LINE_WIDTH = 8'd80;
    localparam logic [7:0]          RST_PAGE_LINES = 8'd24;

    // configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_TAB_WIDTH  = 2'd0;
    localparam logic [CFG_BITS-1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_BITS-1:0] CFG_PAGE_LINES = 2'd2;

    // request kinds
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // character and key codes
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] KEY_QUIT = 8'h71;
    localparam logic [7:0] KEY_CTRL = 8'h03;

    typedef struct packed {
        logic                start;
        logic [POS_BITS-1:0] dividend;
        logic [TAB_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [POS_BITS-1:0] quot;
        logic [REM_BITS-1:0] rem;
    } t_div_rsp;

    // one result item; accepted sits in the lowest bit
    typedef struct packed {
        logic [LINE_BITS-1:0] line_count;
        logic [7:0]           column;
        logic                 quit;
        logic                 wrap_newline;
        logic [7:0]           out_char;
        logic                 char_valid;
        logic [3:0]           space_count;
        logic [7:0]           tab_count;
        logic                 more_prompt;
        logic                 accepted;
    } t_result;

    localparam int RES_BITS   = $bits(t_result);
    localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    // tab width 0 acts as 1, above 16 acts as 16
    function automatic logic [TAB_BITS-1:0] eff_tab(input logic [TAB_BITS-1:0] tw);
        logic [TAB_BITS-1:0] r;
        if (tw == '0) r = TAB_BITS'(1);
        else if (tw > TAB_BITS'(16)) r = TAB_BITS'(16);
        else r = tw;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/console_whitespace_tab_compressor.sv -----
// Top level: console whitespace/tab compressor with pager line counting.
//
// Slave stream (s): tuser = req_type (0 character, 1 pager key), tdata = code.
// Master stream (m): one result item per input item, fields packed in tdata.
// Config channel: i_cfg_index selects tab_width (0), line_width (1) or
// page_lines (2); writes are always taken, other indexes are ignored.
// Write config only while the block is idle with no result pending.
//
// One item at a time. After acceptance the item is decoded in S_EXEC.
// A printing character with pending whitespace runs the shared
// divider twice (current column, then last printed column); a tab runs it
// once. Items pass S_EXEC, then S_DIVC and S_DIVP as needed, then S_FIN
// to reach the result register; o_s_tready is low meanwhile.
// The result register holds the item while the receiver stalls. The next
// item is still taken and worked up to its final step, where it waits for
// the result slot; o_s_tready then stays low until that slot frees up.
// A full page returns accepted=0 with more_prompt=1 and no state change.
// Reset (synchronous, active low) zeroes columns and line count and
// restores tab width 8, line width 80, page length 24.
`default_nettype none
module console_whitespace_tab_compressor (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,   // [7:0] code
    input  wire logic                              i_s_tuser,   // [0] req_type
    // master stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [0] accepted, [1] more_prompt, [9:2] tab_count, [13:10] space_count,
    // [14] char_valid, [22:15] out_char, [23] wrap_newline, [24] quit,
    // [32:25] column, [40:33] line_count, [47:41] zero
    output logic [cwtc_pkg::TDATA_BITS-1:0]        o_m_tdata,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [cwtc_pkg::CFG_BITS-1:0]     i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data
);
    import cwtc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIVC,
        S_DIVP,
        S_FIN
    } t_state;

    t_state                r_state;

    // configuration
    logic [TAB_BITS-1:0]   r_tab_width;
    logic [7:0]            r_line_width;
    logic [7:0]            r_page_lines;

    // tracking state
    logic [POS_BITS-1:0]   r_cur;
    logic [POS_BITS-1:0]   r_prn;
    logic [LINE_BITS-1:0]  r_lines;

    // latched item and divide results
    logic                  r_req;
    logic [7:0]            r_code;
    logic [POS_BITS-1:0]   r_qc;
    logic [REM_BITS-1:0]   r_rc;
    logic [POS_BITS-1:0]   r_qp;

    logic                  r_ovalid;
    t_result               r_out;

    t_div_req              w_dreq;
    t_div_rsp              w_drsp;

    logic [TAB_BITS-1:0]   w_tw;
    logic                  w_page_full;
    logic                  w_print;
    logic                  w_behind;
    logic                  w_need_divc;
    logic                  w_slot_free;

    t_result               n_out;
    logic [POS_BITS-1:0]   n_cur;
    logic [POS_BITS-1:0]   n_prn;
    logic [LINE_BITS-1:0]  n_lines;
    logic [POS_BITS-1:0]   w_pos_inc;
    logic [POS_BITS:0]     w_next_stop;
    logic [7:0]            w_tabs;

    cwtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // decode of the latched item
    always_comb begin
        w_tw        = eff_tab(r_tab_width);
        w_page_full = (r_page_lines >= MIN_PAGE_LINES) &&
                      (r_lines >= (r_page_lines - 8'd1));
        w_print     = (r_code > CH_SPACE) && (r_code <= CH_TILDE);
        w_behind    = (r_prn < r_cur);   // whitespace still owed
        w_need_divc = (r_req == REQ_CHAR) && !w_page_full &&
                      ((w_print && w_behind) || (r_code == CH_TAB));
        w_slot_free = !r_ovalid || i_m_tready;
    end

    // divider: current column first, printed column second
    always_comb begin
        w_dreq.start    = ((r_state == S_EXEC) && w_need_divc) ||
                          ((r_state == S_DIVC) && w_drsp.done && w_print);
        w_dreq.dividend = (r_state == S_EXEC) ? r_cur : r_prn;
        w_dreq.divisor  = w_tw;
    end

    // result and next tracking state, applied in S_FIN
    always_comb begin
        n_out       = '0;
        n_out.accepted = 1'b1;
        n_cur       = r_cur;
        n_prn       = r_prn;
        n_lines     = r_lines;
        w_pos_inc   = (r_cur == POS_MAX) ? POS_MAX : r_cur + POS_BITS'(1);
        w_next_stop = {1'b0, r_cur} - (POS_BITS+1)'(r_rc) + (POS_BITS+1)'(w_tw);
        w_tabs      = 8'(r_qc - r_qp);

        if (r_req == REQ_KEY) begin
            if (r_code == CH_SPACE) begin
                n_lines = '0;
            end else if (r_code == KEY_QUIT || r_code == KEY_CTRL) begin
                n_lines    = '0;
                n_out.quit = 1'b1;
            end else if (r_lines != '0) begin
                n_lines = r_lines - LINE_BITS'(1);
            end
        end else if (w_page_full) begin
            n_out.accepted    = 1'b0;
            n_out.more_prompt = 1'b1;
        end else if (w_print) begin
            if (w_behind) begin
                n_out.tab_count   = w_tabs;
                // with no tab, the gap stays inside one tab stop (< 16)
                n_out.space_count = (w_tabs != 8'd0) ? r_rc : 4'(r_cur - r_prn);
            end
            n_out.char_valid = 1'b1;
            n_out.out_char   = r_code;
            n_cur            = w_pos_inc;
            if (r_line_width >= MIN_WRAP_WIDTH &&
                w_pos_inc >= POS_BITS'(r_line_width - 8'd1)) begin
                n_out.wrap_newline = 1'b1;
                n_cur   = '0;
                n_lines = (r_lines == LINE_MAX) ? LINE_MAX : r_lines + LINE_BITS'(1);
            end
            n_prn = n_cur;
        end else if (r_code == CH_LF) begin
            n_out.char_valid = 1'b1;
            n_out.out_char   = r_code;
            n_cur   = '0;
            n_prn   = '0;
            n_lines = (r_lines == LINE_MAX) ? LINE_MAX : r_lines + LINE_BITS'(1);
        end else if (r_code == CH_TAB) begin
            n_cur = (w_next_stop > (POS_BITS+1)'(POS_MAX)) ? POS_MAX :
                    w_next_stop[POS_BITS-1:0];
        end else if (r_code == CH_SPACE) begin
            n_cur = w_pos_inc;
        end else if (r_code == CH_BEL) begin
            n_out.char_valid = 1'b1;
            n_out.out_char   = r_code;
        end
        n_out.column     = 8'(n_cur);
        n_out.line_count = n_lines;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_tab_width  <= RST_TAB_WIDTH;
            r_line_width <= RST_LINE_WIDTH;
            r_page_lines <= RST_PAGE_LINES;
            r_cur        <= '0;
            r_prn        <= '0;
            r_lines      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TAB_WIDTH:  r_tab_width  <= i_cfg_data[TAB_BITS-1:0];
                    CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                    CFG_PAGE_LINES: r_page_lines <= i_cfg_data;
                    default: ;
                endcase
            end

            // result slot: filled in S_FIN, emptied by the receiver
            if (r_state == S_FIN && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_req   <= i_s_tuser;
                        r_code  <= i_s_tdata;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= w_need_divc ? S_DIVC : S_FIN;
                end
                S_DIVC: begin
                    if (w_drsp.done) begin
                        r_qc    <= w_drsp.quot;
                        r_rc    <= w_drsp.rem;
                        r_state <= w_print ? S_DIVP : S_FIN;
                    end
                end
                S_DIVP: begin
                    if (w_drsp.done) begin
                        r_qp    <= w_drsp.quot;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_out    <= n_out;
                        r_cur    <= n_cur;
                        r_prn    <= n_prn;
                        r_lines  <= n_lines;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {(TDATA_BITS-RES_BITS)'(0), r_out};
    assign o_cfg_ready = 1'b1;

    // divider answers only arrive while a divide phase waits for them
    a_div_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_DIVC || r_state == S_DIVP))
        else $error("divider done outside a divide phase");

    // the last printed column never runs ahead of the current column
    a_prn_le_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prn <= r_cur)
        else $error("printed column ahead of current column");

    // a refused item carries the prompt and nothing to send
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out.accepted) |->
            (r_out.more_prompt && !r_out.char_valid && r_out.tab_count == 8'd0))
        else $error("refused item with output content");

    // an accepted input item is decoded in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted item not decoded");

    // a result is written only when the slot was free or being emptied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ovalid && !i_m_tready) |=> (r_state == S_FIN))
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ----- rtl/core/cwtc_div.sv -----
// Iterative restoring divider: 8-bit column by 1..16 tab width, one quotient bit a cycle.
`default_nettype none
module cwtc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cwtc_pkg::t_div_req i_req,
    output cwtc_pkg::t_div_rsp      o_rsp
);
    import cwtc_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(POS_BITS - 1);

    logic [POS_BITS-1:0] r_quo;
    logic [REM_BITS-1:0] r_rem;
    logic [TAB_BITS-1:0] r_dvs;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [REM_BITS:0]   w_trial;
    logic [REM_BITS:0]   w_diff;
    logic                w_ge;

    // partial remainder is below the divisor, so one more bit fits in REM_BITS+1
    always_comb begin
        w_trial = {r_rem, r_quo[POS_BITS-1]};
        w_ge    = (w_trial >= (REM_BITS+1)'(r_dvs));
        w_diff  = w_trial - (REM_BITS+1)'(r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // one-cycle pulse after the last quotient bit
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_LAST);
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[POS_BITS-2:0], w_ge};
                r_rem <= w_ge ? w_diff[REM_BITS-1:0] : w_trial[REM_BITS-1:0];
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire
